// ===== hw/rtl/hbs_pkg.sv =====
// Shared types and constants of the heightmap bilinear sampler.
// No dependencies; every other file of the block imports this package.
package hbs_pkg;

  // Field widths of the item and result ports.
  localparam int POS_W  = 24;  // signed Q16.8 world position
  localparam int HGT_W  = 16;  // signed Q8.8 height
  localparam int IDX_W  = 13;  // grid entry index of a write item
  localparam int FRAC_W = 8;   // fractional bits of a grid coordinate

  // Grid coordinate after origin removal and half-width offset.
  localparam int GX_W  = 26;
  // Intermediate widths of the interpolation datapath.
  localparam int DIF_W = HGT_W + 1;  // difference of two corner heights
  localparam int TOP_W = 26;         // one edge interpolated, Q.16
  localparam int ACC_W = 36;         // full bilinear value, Q.24

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 24;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 1'd1;

  // Command codes of an input item.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Depth of the queue between front and back end.
  localparam int QUEUE_DEPTH = 4;

  // Operation handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_OUTSIDE = 2'd2
  } hbs_op_e;

endpackage

// ===== hw/rtl/heightmap_bilinear_sampler.sv =====
// Top level of the heightmap bilinear sampler.
// Depends on hbs_pkg, hbs_front, hbs_queue and hbs_back.
//
// Usage:
//   Configuration: cfg_we_i, cfg_idx_i and cfg_data_i write the grid origin
//   (index 0 is origin x, index 1 origin z), taken at any clock edge.
//   Items: an item is taken at a rising edge with start high and busy low.
//   command_i low stores entry_height_i at entry_index_i (an index beyond
//   the grid is dropped); command_i high samples the grid at pos_x_i/pos_z_i.
//   Results: each sample item gives one result, shown on height_o and
//   outside_o for the single cycle in which valid_o is high. Write items give
//   no result. Results come out in item order and must be taken when shown.
//   Path: every sample passes the input stage, the queue, the read stage,
//   the interpolation stages s1 to s4 and the output register; one inside the
//   grid first reads all four corners. Queued items wait for earlier ones.
//   Throughput: a sample occupies the single grid read port with one read per
//   corner, and the back end takes no new item before its far corner is read;
//   writes at one per cycle while no sample holds it. A four-entry queue lets
//   the front take items during corner reads; busy rises only if it is full.
//   Reset clears the origin and all control state; grid entries hold no
//   defined value until written.
module heightmap_bilinear_sampler #(
  parameter int GRID_QUADS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  cfg_we_i,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [hbs_pkg::CFG_W-1:0]             cfg_data_i,
  input  logic                                  command_i,
  input  logic signed [hbs_pkg::POS_W-1:0]      pos_x_i,
  input  logic signed [hbs_pkg::POS_W-1:0]      pos_z_i,
  input  logic [hbs_pkg::IDX_W-1:0]             entry_index_i,
  input  logic signed [hbs_pkg::HGT_W-1:0]      entry_height_i,
  output logic                                  valid_o,
  output logic signed [hbs_pkg::HGT_W-1:0]      height_o,
  output logic                                  outside_o
);
  import hbs_pkg::*;

  localparam int GRID_VERTS = GRID_QUADS + 1;
  localparam int AW         = $clog2(GRID_VERTS * GRID_VERTS);
  localparam int OP_W       = $bits(hbs_op_e);
  localparam int QW         = OP_W + AW + HGT_W;

  logic              push, pop, full, empty;
  hbs_op_e           push_op, pop_op;
  logic [AW-1:0]     push_addr, pop_addr;
  logic [HGT_W-1:0]  push_data, pop_data;
  logic [QW-1:0]     q_in, q_out;

  hbs_front #(
    .GRID_QUADS(GRID_QUADS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .command_i      (command_i),
    .pos_x_i        (pos_x_i),
    .pos_z_i        (pos_z_i),
    .entry_index_i  (entry_index_i),
    .entry_height_i (entry_height_i),
    .full_i         (full),
    .push_o         (push),
    .op_o           (push_op),
    .addr_o         (push_addr),
    .data_o         (push_data)
  );

  assign q_in = {push_op, push_addr, push_data};

  hbs_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (q_in),
    .pop_i       (pop),
    .pop_data_o  (q_out),
    .full_o      (full),
    .empty_o     (empty)
  );

  assign pop_op   = hbs_op_e'(q_out[QW-1 -: OP_W]);
  assign pop_addr = q_out[HGT_W +: AW];
  assign pop_data = q_out[HGT_W-1:0];

  hbs_back #(
    .GRID_QUADS(GRID_QUADS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .op_i      (pop_op),
    .addr_i    (pop_addr),
    .data_i    (pop_data),
    .pop_o     (pop),
    .valid_o   (valid_o),
    .height_o  (height_o),
    .outside_o (outside_o)
  );

endmodule

// ===== hw/rtl/hbs_front.sv =====
// Front end: takes items, holds the grid origin, converts positions into
// cell and fraction and classifies each item. Depends on hbs_pkg.
module hbs_front #(
  parameter int GRID_QUADS = 64
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     cfg_we_i,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]            cfg_idx_i,
  input  logic [hbs_pkg::CFG_W-1:0]                cfg_data_i,
  input  logic                                     command_i,
  input  logic signed [hbs_pkg::POS_W-1:0]         pos_x_i,
  input  logic signed [hbs_pkg::POS_W-1:0]         pos_z_i,
  input  logic [hbs_pkg::IDX_W-1:0]                entry_index_i,
  input  logic signed [hbs_pkg::HGT_W-1:0]         entry_height_i,
  input  logic                                     full_i,
  output logic                                     push_o,
  output hbs_pkg::hbs_op_e                         op_o,
  output logic [$clog2((GRID_QUADS+1)*(GRID_QUADS+1))-1:0] addr_o,
  output logic [hbs_pkg::HGT_W-1:0]                data_o
);
  import hbs_pkg::*;

  localparam int GRID_VERTS = GRID_QUADS + 1;
  localparam int DEPTH      = GRID_VERTS * GRID_VERTS;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = GX_W - 1 - FRAC_W;
  localparam logic [CW-1:0] CELL_LIM = CW'(GRID_QUADS);
  localparam logic [AW-1:0] VERTS_A  = AW'(GRID_VERTS);
  localparam logic [GX_W-1:0] HALF_W = GX_W'(GRID_QUADS * 128);

  logic signed [CFG_W-1:0] origin_x_q, origin_z_q;
  logic                    stg_vld_q, stg_vld_d;
  logic                    stg_cmd_q;
  logic signed [GX_W-1:0]  gx_q, gz_q, gx_d, gz_d;
  logic [IDX_W-1:0]        idx_q;
  logic [HGT_W-1:0]        hgt_q;
  logic                    accept;
  logic                    outside;
  logic                    idx_ok;
  logic [CW-1:0]           x_cell, z_cell;
  logic [AW-1:0]           base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORIGIN_X: origin_x_q <= cfg_data_i;
        REG_ORIGIN_Z: origin_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = start & ~busy;
  assign gx_d   = GX_W'(pos_x_i) - GX_W'(origin_x_q) + $signed(HALF_W);
  assign gz_d   = GX_W'(pos_z_i) - GX_W'(origin_z_q) + $signed(HALF_W);

  // The item stays in the stage while the queue is full.
  assign busy      = stg_vld_q & full_i;
  assign stg_vld_d = accept | busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else begin
      stg_vld_q <= stg_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_cmd_q <= command_i;
      gx_q      <= gx_d;
      gz_q      <= gz_d;
      idx_q     <= entry_index_i;
      hgt_q     <= entry_height_i;
    end
  end

  // A cell is inside when both coordinates are non-negative and the cell
  // index leaves room for the far corner.
  assign x_cell  = gx_q[GX_W-2:FRAC_W];
  assign z_cell  = gz_q[GX_W-2:FRAC_W];
  assign outside = gx_q[GX_W-1] | gz_q[GX_W-1] | (x_cell >= CELL_LIM) | (z_cell >= CELL_LIM);
  assign base    = AW'(z_cell) * VERTS_A + AW'(x_cell);
  assign idx_ok  = 32'(idx_q) < DEPTH;

  assign push_o = stg_vld_q & ~full_i & ((stg_cmd_q == CMD_QUERY) | idx_ok);

  always_comb begin
    if (stg_cmd_q == CMD_QUERY) begin
      op_o   = outside ? OP_OUTSIDE : OP_SAMPLE;
      addr_o = base;
      data_o = {gx_q[FRAC_W-1:0], gz_q[FRAC_W-1:0]};
    end else begin
      op_o   = OP_WRITE;
      addr_o = AW'(idx_q);
      data_o = hgt_q;
    end
  end

endmodule

// ===== hw/rtl/hbs_queue.sv =====
// Small first-in first-out queue between the front and the back end.
// Depends on hbs_pkg for its depth.
module hbs_queue #(
  parameter int WIDTH = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);
  import hbs_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PW:0]      count_q, count_d;

  assign full_o     = count_q == (PW+1)'(QUEUE_DEPTH);
  assign empty_o    = count_q == '0;
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/hbs_back.sv =====
// Back end: grid memory, corner read sequencer and the interpolation
// pipeline that produces results. Depends on hbs_pkg.
module hbs_back #(
  parameter int GRID_QUADS = 64
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     empty_i,
  input  hbs_pkg::hbs_op_e                         op_i,
  input  logic [$clog2((GRID_QUADS+1)*(GRID_QUADS+1))-1:0] addr_i,
  input  logic [hbs_pkg::HGT_W-1:0]                data_i,
  output logic                                     pop_o,
  output logic                                     valid_o,
  output logic signed [hbs_pkg::HGT_W-1:0]         height_o,
  output logic                                     outside_o
);
  import hbs_pkg::*;

  localparam int GRID_VERTS = GRID_QUADS + 1;
  localparam int DEPTH      = GRID_VERTS * GRID_VERTS;
  localparam int AW         = $clog2(DEPTH);
  localparam logic [AW-1:0] OFF_RIGHT = AW'(1);
  localparam logic [AW-1:0] OFF_DOWN  = AW'(GRID_VERTS);
  localparam logic [AW-1:0] OFF_DIAG  = AW'(GRID_VERTS + 1);
  localparam logic [1:0] CORNER_00 = 2'd0;
  localparam logic [1:0] CORNER_10 = 2'd1;
  localparam logic [1:0] CORNER_01 = 2'd2;
  localparam logic [1:0] CORNER_11 = 2'd3;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  logic [HGT_W-1:0] grid_mem [DEPTH];

  // Read sequencer.
  logic              active_q, active_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [AW-1:0]     base_q, base_d;
  logic [HGT_W-1:0]  frac_q, frac_d;
  logic              mem_we, rd_re;
  logic [AW-1:0]     rd_addr;
  logic              rd_vld_q, rd_vld_d, rd_out_q, rd_out_d;
  logic [1:0]        rd_sel_q, rd_sel_d;
  logic signed [HGT_W-1:0] rd_data_q;
  logic signed [HGT_W-1:0] h00_q, h10_q, h01_q;

  // Interpolation pipeline.
  logic                    s1_ld;
  logic                    s1_vld_q, s1_out_q, s2_vld_q, s2_out_q;
  logic                    s3_vld_q, s3_out_q, s4_vld_q, s4_out_q;
  logic signed [DIF_W-1:0] s1_dtop_q, s1_dbot_q;
  logic signed [HGT_W-1:0] s1_h00_q, s1_h01_q;
  logic [FRAC_W-1:0]       s1_tx_q, s1_tz_q, s2_tz_q, s3_tz_q;
  logic signed [TOP_W-1:0] s2_top_q, s2_bot_q, s3_top_q, top_d, bot_d;
  logic signed [TOP_W:0]   s3_diff_q;
  logic signed [ACC_W-1:0] s4_v_q, v_d, rounded;
  logic                    out_vld_q;
  logic signed [HGT_W-1:0] height_q, height_d;
  logic                    outside_q;

  assign pop_o = ~empty_i & ~active_q;

  always_comb begin
    mem_we   = 1'b0;
    rd_re    = 1'b0;
    rd_addr  = base_q;
    rd_vld_d = 1'b0;
    rd_out_d = 1'b0;
    rd_sel_d = CORNER_00;
    active_d = active_q;
    cnt_d    = cnt_q;
    base_d   = base_q;
    frac_d   = frac_q;
    if (active_q) begin
      rd_re    = 1'b1;
      rd_vld_d = 1'b1;
      rd_sel_d = cnt_q;
      case (cnt_q)
        CORNER_10: rd_addr = base_q + OFF_RIGHT;
        CORNER_01: rd_addr = base_q + OFF_DOWN;
        CORNER_11: rd_addr = base_q + OFF_DIAG;
        default:   rd_addr = base_q;
      endcase
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == CORNER_11) begin
        active_d = 1'b0;
      end
    end else if (pop_o) begin
      case (op_i)
        OP_WRITE: begin
          mem_we = 1'b1;
        end
        OP_SAMPLE: begin
          rd_re    = 1'b1;
          rd_vld_d = 1'b1;
          rd_addr  = addr_i;
          active_d = 1'b1;
          cnt_d    = CORNER_10;
          base_d   = addr_i;
          frac_d   = data_i;
        end
        OP_OUTSIDE: begin
          // Passes down the read stage so that results keep item order.
          rd_vld_d = 1'b1;
          rd_out_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[addr_i] <= data_i;
    end
    if (rd_re) begin
      rd_data_q <= grid_mem[rd_addr];
    end
  end

  assign s1_ld = rd_vld_q & (rd_out_q | (rd_sel_q == CORNER_11));

  // Datapath arithmetic; each product is registered before the next use.
  assign top_d = $signed({{2{s1_h00_q[HGT_W-1]}}, s1_h00_q, 8'b0})
               + $signed({1'b0, s1_tx_q}) * s1_dtop_q;
  assign bot_d = $signed({{2{s1_h01_q[HGT_W-1]}}, s1_h01_q, 8'b0})
               + $signed({1'b0, s1_tx_q}) * s1_dbot_q;
  assign v_d   = $signed({s3_top_q, 8'b0}) + $signed({1'b0, s3_tz_q}) * s3_diff_q;
  assign rounded  = s4_v_q + ROUND_HALF;
  assign height_d = s4_out_q ? '0 : rounded[31:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      cnt_q     <= CORNER_00;
      rd_vld_q  <= 1'b0;
      rd_out_q  <= 1'b0;
      rd_sel_q  <= CORNER_00;
      s1_vld_q  <= 1'b0;
      s1_out_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_out_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s3_out_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s4_out_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      active_q  <= active_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      rd_out_q  <= rd_out_d;
      rd_sel_q  <= rd_sel_d;
      s1_vld_q  <= s1_ld;
      s1_out_q  <= s1_ld & rd_out_q;
      s2_vld_q  <= s1_vld_q;
      s2_out_q  <= s1_out_q;
      s3_vld_q  <= s2_vld_q;
      s3_out_q  <= s2_out_q;
      s4_vld_q  <= s3_vld_q;
      s4_out_q  <= s3_out_q;
      out_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    frac_q <= frac_d;
    if (rd_vld_q && !rd_out_q) begin
      case (rd_sel_q)
        CORNER_00: h00_q <= rd_data_q;
        CORNER_10: h10_q <= rd_data_q;
        CORNER_01: h01_q <= rd_data_q;
        default: ;
      endcase
    end
    if (s1_ld) begin
      s1_dtop_q <= DIF_W'(h10_q) - DIF_W'(h00_q);
      s1_dbot_q <= DIF_W'(rd_data_q) - DIF_W'(h01_q);
      s1_h00_q  <= h00_q;
      s1_h01_q  <= h01_q;
      s1_tx_q   <= frac_q[HGT_W-1:FRAC_W];
      s1_tz_q   <= frac_q[FRAC_W-1:0];
    end
    s2_top_q  <= top_d;
    s2_bot_q  <= bot_d;
    s2_tz_q   <= s1_tz_q;
    s3_top_q  <= s2_top_q;
    s3_diff_q <= (TOP_W+1)'(s2_bot_q) - (TOP_W+1)'(s2_top_q);
    s3_tz_q   <= s2_tz_q;
    s4_v_q    <= v_d;
    height_q  <= height_d;
    outside_q <= s4_out_q;
  end

  assign valid_o   = out_vld_q;
  assign height_o  = height_q;
  assign outside_o = outside_q;

  // The far corner of a cell always follows the three others.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && !rd_out_q && rd_sel_q == CORNER_11)
      |-> ($past(rd_vld_q) && !$past(rd_out_q) && $past(rd_sel_q) == CORNER_01))
    else $error("far corner read out of sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mem_we && rd_re))
    else $error("grid write and read in the same cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_re || mem_we) |-> ((32'(rd_addr) < DEPTH) && (32'(addr_i) < DEPTH || !mem_we)))
    else $error("grid address beyond the grid");

endmodule

// ===== tb/sv/hbs_height_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the heightmap bilinear sampler: keeps its own copy of the grid and
// origin, predicts each sample item and compares it with the result ports.
// Depends on hbs_pkg.
module hbs_height_checker #(
  parameter int GRID_QUADS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic                                  busy_i,
  input  logic                                  cfg_we_i,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [hbs_pkg::CFG_W-1:0]             cfg_data_i,
  input  logic                                  command_i,
  input  logic signed [hbs_pkg::POS_W-1:0]      pos_x_i,
  input  logic signed [hbs_pkg::POS_W-1:0]      pos_z_i,
  input  logic [hbs_pkg::IDX_W-1:0]             entry_index_i,
  input  logic signed [hbs_pkg::HGT_W-1:0]      entry_height_i,
  input  logic                                  valid_i,
  input  logic signed [hbs_pkg::HGT_W-1:0]      height_i,
  input  logic                                  outside_i,
  output int                                    samples_pending_o,
  output int                                    mismatches_o
);
  import hbs_pkg::*;

  localparam int GRID_VERTS = GRID_QUADS + 1;
  localparam int GRID_DEPTH = GRID_VERTS * GRID_VERTS;

  typedef struct packed {
    logic signed [HGT_W-1:0] height;
    logic                    outside;
  } sample_t;

  logic signed [HGT_W-1:0] height_grid [GRID_DEPTH];
  longint                  origin_x;
  longint                  origin_z;
  sample_t                 expected_samples [$];
  int                      mismatch_count = 0;

  // Bilinear sample of the mirrored grid, computed exactly and rounded once at the end.
  function automatic sample_t predict_sample(input logic signed [POS_W-1:0] px,
                                             input logic signed [POS_W-1:0] pz);
    longint  gx, gz, cx, cz, tx, tz, row0, row1;
    longint  h00, h10, h01, h11, top_edge, bottom_edge, acc;
    sample_t s;
    gx = longint'(px) - origin_x + longint'(GRID_QUADS) * 128;
    gz = longint'(pz) - origin_z + longint'(GRID_QUADS) * 128;
    cx = gx >>> FRAC_W;
    cz = gz >>> FRAC_W;
    if (cx < 0 || cx + 1 >= GRID_VERTS || cz < 0 || cz + 1 >= GRID_VERTS) begin
      s.height  = '0;
      s.outside = 1'b1;
      return s;
    end
    tx   = gx & 255;
    tz   = gz & 255;
    row0 = cz * GRID_VERTS;
    row1 = row0 + GRID_VERTS;
    h00  = height_grid[int'(row0 + cx)];
    h10  = height_grid[int'(row0 + cx + 1)];
    h01  = height_grid[int'(row1 + cx)];
    h11  = height_grid[int'(row1 + cx + 1)];
    top_edge    = h00 * 256 + tx * (h10 - h00);
    bottom_edge = h01 * 256 + tx * (h11 - h01);
    acc         = top_edge * 256 + tz * (bottom_edge - top_edge);
    s.height  = HGT_W'((acc + 32768) >>> 16);
    s.outside = 1'b0;
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sample_t want;
    if (!rst_ni) begin
      origin_x = 0;
      origin_z = 0;
      expected_samples.delete();
      samples_pending_o <= 0;
      mismatches_o      <= 0;
    end else begin
      // A result leaves only after its item has passed the input stage and the
      // queue, so checking before taking this edge's item is safe.
      if (valid_i) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result: expected none, got height %0d outside %0b",
                   $time, height_i, outside_i);
          mismatch_count++;
        end else begin
          want = expected_samples.pop_front();
          if (height_i !== want.height || outside_i !== want.outside) begin
            $display({"%0t: sample mismatch: expected height %0d outside %0b, ",
                      "got height %0d outside %0b"},
                     $time, want.height, want.outside, height_i, outside_i);
            mismatch_count++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ORIGIN_X: origin_x = longint'($signed(cfg_data_i));
          REG_ORIGIN_Z: origin_z = longint'($signed(cfg_data_i));
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (command_i == CMD_QUERY) begin
          expected_samples.push_back(predict_sample(pos_x_i, pos_z_i));
        end else if (entry_index_i < GRID_DEPTH) begin
          height_grid[entry_index_i] = entry_height_i;
        end
      end
      samples_pending_o <= expected_samples.size();
      mismatches_o      <= mismatch_count;
    end
  end

endmodule

// ===== tb/sv/tb_heightmap_bilinear_sampler.sv =====
`timescale 1ns / 100ps
// Testbench top for the heightmap bilinear sampler: drives grid writes, origin settings
// and sample items, gives the verdict. Depends on hbs_pkg, the DUT and the checker.
module tb_heightmap_bilinear_sampler;
  import hbs_pkg::*;

  localparam int GRID_QUADS    = 64;
  localparam int GRID_VERTS    = GRID_QUADS + 1;
  localparam int GRID_DEPTH    = GRID_VERTS * GRID_VERTS;
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASE_ITEMS   = 255;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [HGT_W-1:0] HGT_MAX = {1'b0, {(HGT_W-1){1'b1}}};
  localparam logic signed [HGT_W-1:0] HGT_MIN = {1'b1, {(HGT_W-1){1'b0}}};

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_W-1:0]        cfg_data_i;
  logic                    command_i;
  logic signed [POS_W-1:0] pos_x_i;
  logic signed [POS_W-1:0] pos_z_i;
  logic [IDX_W-1:0]        entry_index_i;
  logic signed [HGT_W-1:0] entry_height_i;
  logic                    valid_o;
  logic signed [HGT_W-1:0] height_o;
  logic                    outside_o;
  int                      samples_pending;
  int                      mismatches;

  // Stimulus-side view of the block, used only to steer item generation.
  longint                  origin_x;
  longint                  origin_z;
  int unsigned             idle_pct;
  int                      items_sent;
  bit                      entry_loaded [GRID_DEPTH];

  heightmap_bilinear_sampler #(
    .GRID_QUADS(GRID_QUADS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .command_i     (command_i),
    .pos_x_i       (pos_x_i),
    .pos_z_i       (pos_z_i),
    .entry_index_i (entry_index_i),
    .entry_height_i(entry_height_i),
    .valid_o       (valid_o),
    .height_o      (height_o),
    .outside_o     (outside_o)
  );

  hbs_height_checker #(
    .GRID_QUADS(GRID_QUADS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .command_i        (command_i),
    .pos_x_i          (pos_x_i),
    .pos_z_i          (pos_z_i),
    .entry_index_i    (entry_index_i),
    .entry_height_i   (entry_height_i),
    .valid_i          (valid_o),
    .height_i         (height_o),
    .outside_i        (outside_o),
    .samples_pending_o(samples_pending),
    .mismatches_o     (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic signed [HGT_W-1:0] pick_height();
    case ($urandom_range(7))
      0:       return HGT_MAX;
      1:       return HGT_MIN;
      2:       return '0;
      default: return HGT_W'($urandom);
    endcase
  endfunction

  // A cell coordinate that is inside the grid, just below it or around its far edge.
  function automatic int edge_cell();
    case ($urandom_range(2))
      0:       return int'($urandom_range(GRID_QUADS - 1));
      1:       return int'($urandom_range(3)) - 2;
      default: return GRID_QUADS - 2 + int'($urandom_range(3));
    endcase
  endfunction

  // Start stays high from one item to the next unless an idle cycle is drawn.
  task automatic send_item(input logic cmd, input logic signed [POS_W-1:0] px,
                           input logic signed [POS_W-1:0] pz, input logic [IDX_W-1:0] idx,
                           input logic signed [HGT_W-1:0] hgt);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    command_i      <= cmd;
    pos_x_i        <= px;
    pos_z_i        <= pz;
    entry_index_i  <= idx;
    entry_height_i <= hgt;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (cmd == CMD_QUERY || idx < GRID_DEPTH) items_sent++;
  endtask

  task automatic store_height(input int idx, input logic signed [HGT_W-1:0] hgt);
    send_item(CMD_WRITE, POS_W'($urandom), POS_W'($urandom), IDX_W'(idx), hgt);
    if (idx < GRID_DEPTH) entry_loaded[idx] = 1'b1;
  endtask

  // Corners of an inside cell that were never written get a height first, so that no
  // sample ever reads an undefined entry.
  task automatic query_at(input logic signed [POS_W-1:0] px,
                          input logic signed [POS_W-1:0] pz);
    longint gx, gz, cx, cz;
    int     base, idx;
    gx = longint'(px) - origin_x + GRID_QUADS * 128;
    gz = longint'(pz) - origin_z + GRID_QUADS * 128;
    cx = gx >>> FRAC_W;
    cz = gz >>> FRAC_W;
    if (cx >= 0 && cx < GRID_QUADS && cz >= 0 && cz < GRID_QUADS) begin
      base = int'(cz * GRID_VERTS + cx);
      for (int k = 0; k < 4; k++) begin
        idx = base + (k & 1) + (k >> 1) * GRID_VERTS;
        if (!entry_loaded[idx]) store_height(idx, pick_height());
      end
    end
    send_item(CMD_QUERY, px, pz, IDX_W'($urandom), HGT_W'($urandom));
  endtask

  // Positions that fall outside the 24-bit range wrap and simply land outside the grid.
  task automatic query_cell(input int cx, input int cz, input int tx, input int tz);
    query_at(POS_W'(longint'(cx) * 256 + tx - GRID_QUADS * 128 + origin_x),
             POS_W'(longint'(cz) * 256 + tz - GRID_QUADS * 128 + origin_z));
  endtask

  // Writes leave no result behind, so the settle wait covers any still in the queue.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (samples_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_origin(input logic signed [POS_W-1:0] x,
                            input logic signed [POS_W-1:0] z);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_ORIGIN_X;
    cfg_data_i <= x;
    @(posedge clk_i);
    cfg_idx_i  <= REG_ORIGIN_Z;
    cfg_data_i <= z;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    origin_x = longint'(x);
    origin_z = longint'(z);
  endtask

  initial begin : stimulus
    int phase_end;
    int pick;
    rst_ni         = 1'b0;
    start          = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_ORIGIN_X;
    cfg_data_i     = '0;
    command_i      = CMD_WRITE;
    pos_x_i        = '0;
    pos_z_i        = '0;
    entry_index_i  = '0;
    entry_height_i = '0;
    origin_x       = 0;
    origin_z       = 0;
    idle_pct       = 0;
    items_sent     = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_origin('0, '0);

    // Extreme heights on the first cell, sampled at both fraction extremes.
    store_height(0, HGT_MAX);
    store_height(1, HGT_MIN);
    store_height(GRID_VERTS, HGT_MIN);
    store_height(GRID_VERTS + 1, HGT_MAX);
    query_cell(0, 0, 0, 0);
    query_cell(0, 0, 255, 255);
    // Exact half-way rounding, once upwards from zero and once up to zero.
    store_height(10 * GRID_VERTS + 10, 0);
    store_height(10 * GRID_VERTS + 11, 1);
    store_height(11 * GRID_VERTS + 10, 0);
    store_height(11 * GRID_VERTS + 11, 1);
    query_cell(10, 10, 128, 0);
    store_height(20 * GRID_VERTS + 20, 0);
    store_height(20 * GRID_VERTS + 21, -1);
    store_height(21 * GRID_VERTS + 20, 0);
    store_height(21 * GRID_VERTS + 21, -1);
    query_cell(20, 20, 128, 0);
    // Just outside each of the four grid borders.
    query_cell(-1, 5, 255, 0);
    query_cell(GRID_QUADS, 5, 0, 0);
    query_cell(5, -1, 0, 255);
    query_cell(5, GRID_QUADS, 0, 0);
    // Writes beyond the grid are dropped.
    store_height(GRID_DEPTH, pick_height());
    store_height((1 << IDX_W) - 1, pick_height());
    query_at(POS_MAX, POS_MIN);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: begin
          set_origin(POS_MAX, POS_MIN);
          idle_pct = 71;
        end
        2: begin
          set_origin(POS_MIN, POS_MAX);
          idle_pct = 7;
        end
        3: begin
          set_origin(POS_W'(int'($urandom_range(40000)) - 20000),
                     POS_W'(int'($urandom_range(40000)) - 20000));
          idle_pct = 0;
        end
        4: begin
          set_origin(POS_W'($urandom), POS_W'($urandom));
          idle_pct = 71;
        end
        default: begin
          set_origin(POS_W'(int'($urandom_range(4000)) - 2000),
                     POS_W'(int'($urandom_range(4000)) - 2000));
          idle_pct = 7;
        end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        pick = int'($urandom_range(99));
        if (pick < 40) begin
          store_height(int'($urandom_range(GRID_DEPTH - 1)), pick_height());
        end else if (pick < 45) begin
          store_height(int'($urandom_range((1 << IDX_W) - 1, GRID_DEPTH)), pick_height());
        end else if (pick < 85) begin
          query_cell(int'($urandom_range(GRID_QUADS - 1)), int'($urandom_range(GRID_QUADS - 1)),
                     int'($urandom_range(255)), int'($urandom_range(255)));
        end else if (pick < 93) begin
          query_cell(edge_cell(), edge_cell(), int'($urandom_range(255)),
                     int'($urandom_range(255)));
        end else begin
          query_at(POS_W'($urandom), POS_W'($urandom));
        end
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS heightmap_bilinear_sampler");
    end else begin
      $display("FAIL heightmap_bilinear_sampler");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("FAIL heightmap_bilinear_sampler");
    $finish;
  end

endmodule

// ===== heightmap_bilinear_sampler.f =====
hw/rtl/hbs_pkg.sv
hw/rtl/hbs_front.sv
hw/rtl/hbs_queue.sv
hw/rtl/hbs_back.sv
hw/rtl/heightmap_bilinear_sampler.sv
tb/sv/hbs_height_checker.sv
tb/sv/tb_heightmap_bilinear_sampler.sv
